// ----- src/load_cell_trimmed_mean_scaler_unit_macros.svh -----
// assertion macros for the load cell trimmed mean scaler
`ifndef LOAD_CELL_TRIMMED_MEAN_SCALER_UNIT_MACROS_SVH
`define LOAD_CELL_TRIMMED_MEAN_SCALER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LCTS_ASSERT_HOLDS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("lcts check failed");
`define LCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
		else $error("lcts check failed");
`else
`define LCTS_ASSERT_HOLDS(label, clk, rst_n, prop)
`define LCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/lcts_pkg.sv -----
// shared constants for the load cell trimmed mean scaler
package lcts_pkg;

	localparam int GROUP_SIZE_DEF  = 8;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int TRIM_COUNT      = 2;
	localparam int GAIN_BITS       = 32;
	localparam int GAIN_FRAC_BITS  = 24;
	localparam int OUT_FRAC_BITS   = 8;
	localparam int WEIGHT_BITS     = 32;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 2;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_TARE = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN = CFG_INDEX_BITS'(1);

endpackage

// ----- src/load_cell_trimmed_mean_scaler_unit.sv -----
// load cell trimmed mean scaler: group accumulate, trim, divide, tare, gain, saturate
// a group's result moves through stages s1 to s5, then the output register
// one item per cycle, but a group's last waits on an output stall; one result per GROUP_SIZE items
// the five-stage result pipeline and output register stall together while a result is not taken
// reset clears the group state, the pipeline valids, the tare (0) and the gain (1.0 in Q8.24)
`include "load_cell_trimmed_mean_scaler_unit_macros.svh"

module load_cell_trimmed_mean_scaler_unit #(
	parameter int GROUP_SIZE  = lcts_pkg::GROUP_SIZE_DEF,
	parameter int SAMPLE_BITS = lcts_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          s_axis_tvalid,
	output logic                                          s_axis_tready,
	// raw_sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]              s_axis_tdata,
	output logic                                          m_axis_tvalid,
	input  logic                                          m_axis_tready,
	// average_count, weight_reading
	output logic [((SAMPLE_BITS+lcts_pkg::WEIGHT_BITS+7)/8)*8-1:0] m_axis_tdata,
	// saturated
	output logic                                          m_axis_tuser,
	input  logic                                          cfg_we,
	input  logic [lcts_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [lcts_pkg::CFG_DATA_BITS-1:0]            cfg_wdata
);

	localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + lcts_pkg::WEIGHT_BITS + 7) / 8) * 8;
	localparam int CNT_BITS   = $clog2(GROUP_SIZE);
	localparam int SUM_BITS   = SAMPLE_BITS + $clog2(GROUP_SIZE);
	localparam int DIV        = GROUP_SIZE - lcts_pkg::TRIM_COUNT;
	localparam int RECIP_BITS = SUM_BITS + 1;
	localparam int RPROD_BITS = SUM_BITS + RECIP_BITS;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SUM_BITS) / 64'(DIV);
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_FULL[RECIP_BITS-1:0];
	localparam int NET_BITS   = SAMPLE_BITS + 1;
	localparam int SHIFT      = lcts_pkg::GAIN_FRAC_BITS - lcts_pkg::OUT_FRAC_BITS;
	localparam int NPROD_MIN  = NET_BITS + lcts_pkg::GAIN_BITS;
	localparam int NPROD_BITS = (NPROD_MIN > lcts_pkg::WEIGHT_BITS + SHIFT + 1) ?
		NPROD_MIN : lcts_pkg::WEIGHT_BITS + SHIFT + 1;
	localparam int Q_BITS     = NPROD_BITS - SHIFT;
	localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(GROUP_SIZE - 1);
	localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [Q_BITS-1:0] Q_HI =
		{{(Q_BITS-lcts_pkg::WEIGHT_BITS+1){1'b0}}, {(lcts_pkg::WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [Q_BITS-1:0] Q_LO =
		{{(Q_BITS-lcts_pkg::WEIGHT_BITS+1){1'b1}}, {(lcts_pkg::WEIGHT_BITS-1){1'b0}}};

	logic [SAMPLE_BITS-1:0]                 tare_q;
	logic signed [lcts_pkg::GAIN_BITS-1:0]  gain_q;

	logic [CNT_BITS-1:0]    count_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SAMPLE_BITS-1:0] min_q;

	logic                   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [SUM_BITS-1:0]    sum_s1;
	logic [SAMPLE_BITS-1:0] max_s1, min_s1;
	logic [SUM_BITS-1:0]    trimmed_s2, trimmed_s3;
	logic [RPROD_BITS-1:0]  rprod_s3;
	logic [SAMPLE_BITS-1:0] mean_s4, mean_s5;
	logic signed [NPROD_BITS-1:0] nprod_s5;

	logic                                     out_valid_q;
	logic [SAMPLE_BITS-1:0]                   mean_q;
	logic [lcts_pkg::WEIGHT_BITS-1:0]         weight_q;
	logic                                     sat_q;

	logic                   en;
	logic                   last_sample;
	logic                   in_fire;
	logic [SAMPLE_BITS-1:0] sample;
	logic [SUM_BITS-1:0]    sum_next;
	logic [SAMPLE_BITS-1:0] max_next, min_next;
	logic [SUM_BITS-1:0]    quot_est, rem_est, quot;
	logic signed [NET_BITS-1:0] net;
	logic signed [Q_BITS-1:0]   q_full;

	assign en            = !out_valid_q || m_axis_tready;
	assign last_sample   = (count_q == LAST_CNT);
	assign s_axis_tready = en || !last_sample;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	assign sample   = s_axis_tdata[SAMPLE_BITS-1:0] ^ SIGN_FLIP;
	assign sum_next = sum_q + SUM_BITS'(sample);
	assign max_next = (sample > max_q) ? sample : max_q;
	assign min_next = (sample < min_q) ? sample : min_q;

	assign quot_est = rprod_s3[SUM_BITS +: SUM_BITS];
	assign rem_est  = trimmed_s3 - SUM_BITS'(quot_est * SUM_BITS'(DIV));
	assign quot     = (rem_est >= SUM_BITS'(DIV)) ? quot_est + SUM_BITS'(1) : quot_est;

	assign net    = signed'({1'b0, mean_s4}) - signed'({1'b0, tare_q});
	assign q_full = Q_BITS'(nprod_s5 >>> SHIFT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= '0;
			gain_q <= signed'(lcts_pkg::GAIN_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				lcts_pkg::REG_TARE: tare_q <= cfg_wdata[SAMPLE_BITS-1:0];
				lcts_pkg::REG_GAIN: gain_q <= signed'(cfg_wdata[lcts_pkg::GAIN_BITS-1:0]);
				default: ;
			endcase
		end
	end

	// group accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			min_q   <= '1;
		end else if (in_fire) begin
			if (last_sample) begin
				count_q <= '0;
				sum_q   <= '0;
				max_q   <= '0;
				min_q   <= '1;
			end else begin
				count_q <= count_q + CNT_BITS'(1);
				sum_q   <= sum_next;
				max_q   <= max_next;
				min_q   <= min_next;
			end
		end
	end

	// result pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_fire && last_sample;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	// result pipeline data
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= sum_next;
			max_s1     <= max_next;
			min_s1     <= min_next;
			trimmed_s2 <= sum_s1 - SUM_BITS'(max_s1) - SUM_BITS'(min_s1);
			trimmed_s3 <= trimmed_s2;
			rprod_s3   <= RPROD_BITS'(trimmed_s2) * RPROD_BITS'(RECIP);
			mean_s4    <= quot[SAMPLE_BITS-1:0];
			mean_s5    <= mean_s4;
			nprod_s5   <= NPROD_BITS'(net) * NPROD_BITS'(gain_q);
			mean_q     <= mean_s5;
			if (q_full > Q_HI) begin
				weight_q <= Q_HI[lcts_pkg::WEIGHT_BITS-1:0];
				sat_q    <= 1'b1;
			end else if (q_full < Q_LO) begin
				weight_q <= Q_LO[lcts_pkg::WEIGHT_BITS-1:0];
				sat_q    <= 1'b1;
			end else begin
				weight_q <= q_full[lcts_pkg::WEIGHT_BITS-1:0];
				sat_q    <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_BITS'({weight_q, mean_q});
	assign m_axis_tuser  = sat_q;

	`LCTS_ASSERT_NEXT(a_group_end_loads, clk, arst_n, (in_fire && last_sample), valid_s1)
	`LCTS_ASSERT_NEXT(a_count_steps, clk, arst_n, (in_fire && !last_sample), (count_q == $past(count_q) + CNT_BITS'(1)))
	`LCTS_ASSERT_HOLDS(a_stall_only_at_end, clk, arst_n, (!s_axis_tready |-> (out_valid_q && !m_axis_tready && last_sample)))
	`LCTS_ASSERT_HOLDS(a_sat_at_bound, clk, arst_n, ((out_valid_q && sat_q) |-> (weight_q == Q_HI[lcts_pkg::WEIGHT_BITS-1:0] || weight_q == Q_LO[lcts_pkg::WEIGHT_BITS-1:0])))
	`LCTS_ASSERT_HOLDS(a_max_over_min, clk, arst_n, ((count_q != '0) |-> (max_q >= min_q)))

endmodule

// ----- bench/load_cell_reading_checker.sv -----
`timescale 1ns / 100ps
// checker for the trimmed mean scaler: mirrors registers and group state, compares each output item
module load_cell_reading_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	input  logic                                   s_axis_tready,
	// raw_sample
	input  logic [lcts_pkg::SAMPLE_BITS_DEF-1:0]   s_axis_tdata,
	input  logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// average_count, weight_reading
	input  logic [lcts_pkg::SAMPLE_BITS_DEF+lcts_pkg::WEIGHT_BITS-1:0] m_axis_tdata,
	// saturated
	input  logic                                   m_axis_tuser,
	input  logic                                   cfg_we,
	input  logic [lcts_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [lcts_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
	output int                                     fail_count,
	output int                                     pending,
	output int                                     checked,
	output int                                     clipped
);

	localparam int SAMPLE_W = lcts_pkg::SAMPLE_BITS_DEF;
	localparam int WEIGHT_W = lcts_pkg::WEIGHT_BITS;
	localparam int GAIN_W   = lcts_pkg::GAIN_BITS;
	localparam logic [SAMPLE_W-1:0] SIGN_FLIP = SAMPLE_W'(1) << (SAMPLE_W - 1);
	localparam int OUT_SHIFT = lcts_pkg::GAIN_FRAC_BITS - lcts_pkg::OUT_FRAC_BITS;
	localparam int KEPT = lcts_pkg::GROUP_SIZE_DEF - lcts_pkg::TRIM_COUNT;

	typedef struct packed {
		logic [SAMPLE_W-1:0]    average;
		logic [WEIGHT_W-1:0]    weight;
		logic                   clipped;
	} reading_t;

	reading_t expected_readings[$];

	logic [SAMPLE_W-1:0]         tare;
	logic signed [GAIN_W-1:0]    gain;
	int                          fill;
	logic [31:0]                 group_total;
	logic [SAMPLE_W-1:0]         group_hi;
	logic [SAMPLE_W-1:0]         group_lo;

	task automatic clear_group();
		fill = 0;
		group_total = '0;
		group_hi = '0;
		group_lo = '1;
	endtask

	task automatic fold_sample(input logic [SAMPLE_W-1:0] raw);
		logic [SAMPLE_W-1:0] s;
		logic [SAMPLE_W-1:0] avg;
		logic signed [63:0]  net;
		logic signed [63:0]  prod;
		logic signed [63:0]  scaled;
		reading_t            r;
		s = raw ^ SIGN_FLIP;
		group_total += 32'(s);
		if (s > group_hi)
			group_hi = s;
		if (s < group_lo)
			group_lo = s;
		fill++;
		if (fill == lcts_pkg::GROUP_SIZE_DEF) begin
			avg = SAMPLE_W'((group_total - 32'(group_hi) - 32'(group_lo)) / 32'(KEPT));
			clear_group();
			net = $signed({40'b0, avg}) - $signed({40'b0, tare});
			prod = net * $signed({{32{gain[GAIN_W-1]}}, gain});
			// arithmetic shift floors toward minus infinity
			scaled = prod >>> OUT_SHIFT;
			r.clipped = 1'b0;
			if (scaled > 64'sd2147483647) begin
				scaled = 64'sd2147483647;
				r.clipped = 1'b1;
			end else if (scaled < -64'sd2147483648) begin
				scaled = -64'sd2147483648;
				r.clipped = 1'b1;
			end
			r.average = avg;
			r.weight = scaled[WEIGHT_W-1:0];
			expected_readings.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t               want;
		logic [SAMPLE_W-1:0]    got_avg;
		logic [WEIGHT_W-1:0]    got_weight;
		if (!arst_n) begin
			tare = '0;
			gain = lcts_pkg::GAIN_RESET;
			clear_group();
			expected_readings.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			clipped = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					lcts_pkg::REG_TARE: tare = cfg_wdata[SAMPLE_W-1:0];
					lcts_pkg::REG_GAIN: gain = cfg_wdata[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				fold_sample(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got_avg = m_axis_tdata[SAMPLE_W-1:0];
				got_weight = m_axis_tdata[SAMPLE_W+WEIGHT_W-1:SAMPLE_W];
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected item avg %h weight %h saturated %b",
						$time, got_avg, got_weight, m_axis_tuser);
					fail_count++;
				end else begin
					want = expected_readings.pop_front();
					checked++;
					if (want.clipped)
						clipped++;
					if (got_avg !== want.average) begin
						$display("%0t: average_count expected %h actual %h",
							$time, want.average, got_avg);
						fail_count++;
					end
					if (got_weight !== want.weight) begin
						$display("%0t: weight_reading expected %h actual %h",
							$time, want.weight, got_weight);
						fail_count++;
					end
					if (m_axis_tuser !== want.clipped) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.clipped, m_axis_tuser);
						fail_count++;
					end
				end
			end
			pending = expected_readings.size();
		end
	end

endmodule

// ----- bench/load_cell_trimmed_mean_scaler_unit_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the trimmed mean scaler: reset, register writes, paced samples and verdict
module load_cell_trimmed_mean_scaler_unit_tb;

	localparam int SAMPLE_W = lcts_pkg::SAMPLE_BITS_DEF;
	localparam int GROUP_N  = lcts_pkg::GROUP_SIZE_DEF;
	localparam int IDX_W    = lcts_pkg::CFG_INDEX_BITS;
	localparam int DATA_W   = lcts_pkg::CFG_DATA_BITS;
	localparam int RESULT_W = ((SAMPLE_W + lcts_pkg::WEIGHT_BITS + 7) / 8) * 8;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTINGS_PER_PACE = 4;
	localparam int GROUPS_PER_SETTING = 18;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	// raw_sample
	logic [SAMPLE_W-1:0]       s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	// average_count, weight_reading
	logic [RESULT_W-1:0]       m_axis_tdata;
	// saturated
	logic                      m_axis_tuser;
	logic                      cfg_we = 1'b0;
	logic [IDX_W-1:0]          cfg_index = lcts_pkg::REG_TARE;
	logic [DATA_W-1:0]         cfg_wdata = '0;

	int fail_count;
	int pending;
	int checked;
	int clipped;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int samples_sent = 0;
	int settings_used = 0;

	always #2 clk = ~clk;

	load_cell_trimmed_mean_scaler_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	load_cell_reading_checker reading_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata[SAMPLE_W+lcts_pkg::WEIGHT_BITS-1:0]),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.clipped       (clipped)
	);

	// receiver pacing, with a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT)
				break;
		end
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("load_cell_trimmed_mean_scaler_unit_tb: FAIL");
		$finish;
	end

	// called and returns at a falling edge; valid stays high into the next item
	task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= raw;
		do
			@(posedge clk);
		while (!s_axis_tready);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_group();
		logic [SAMPLE_W-1:0] base;
		logic [SAMPLE_W-1:0] raw;
		int                  style;
		style = $urandom_range(9);
		base = SAMPLE_W'($urandom);
		for (int i = 0; i < GROUP_N; i++) begin
			case (style)
				0, 1, 2: raw = SAMPLE_W'($urandom);
				3, 4, 5, 6: raw = base + SAMPLE_W'($urandom_range(63)) - SAMPLE_W'(32);
				7: raw = base;
				default: begin
					case ($urandom_range(3))
						0: raw = 24'h7F_FFFF;
						1: raw = 24'h80_0000;
						2: raw = 24'h00_0000;
						default: raw = 24'hFF_FFFF;
					endcase
				end
			endcase
			send_sample(raw);
		end
	endtask

	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_tare_and_gain(input logic [DATA_W-1:0] tare_word,
			input logic [DATA_W-1:0] gain_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_SPARE_LO;
		cfg_wdata <= $urandom;
		@(negedge clk);
		cfg_index <= lcts_pkg::REG_TARE;
		cfg_wdata <= tare_word;
		@(negedge clk);
		cfg_index <= lcts_pkg::REG_GAIN;
		cfg_wdata <= gain_word;
		@(negedge clk);
		cfg_index <= REG_SPARE_HI;
		cfg_wdata <= $urandom;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [DATA_W-1:0] pick_tare();
		logic [7:0] junk;
		junk = 8'($urandom);
		case ($urandom_range(4))
			0: return {junk, 24'h00_0000};
			1: return {junk, 24'hFF_FFFF};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_gain();
		logic [DATA_W-1:0] mag;
		mag = $urandom_range(32'h0200_0000);
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return lcts_pkg::GAIN_RESET;
			3: return '0;
			4: return $urandom;
			5: return -mag;
			default: return mag;
		endcase
	endfunction

	initial begin : stimulus
		logic [SAMPLE_W-1:0] extremes_group [GROUP_N];
		extremes_group = '{24'h7F_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h80_0000,
			24'h12_3456, 24'hFE_DCBA, 24'h00_0001, 24'hFF_FFFF};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 32;
		recv_idle_pct = 81;

		// reset settings, all samples equal at mid scale: weight clips high
		repeat (GROUP_N) send_sample(24'h00_0000);

		// full-scale tare with unit gain step: negative net, floored
		drain_block();
		load_tare_and_gain(32'h00FF_FFFF, 32'h0000_0001);
		for (int i = 0; i < GROUP_N; i++)
			send_sample(extremes_group[i]);

		// most negative gain on a large mean: weight clips low
		drain_block();
		load_tare_and_gain(32'h0000_0000, 32'h8000_0000);
		repeat (GROUP_N - 1) send_sample(24'h7F_FFFF);
		send_sample(24'h80_0000);

		for (int pace = 0; pace < 3; pace++) begin
			case (pace)
				0: begin
					send_idle_pct = 32;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < SETTINGS_PER_PACE; k++) begin
				drain_block();
				if (pace == 0 && k == 0)
					load_tare_and_gain(32'h0000_0000, 32'h7FFF_FFFF);
				else
					load_tare_and_gain(pick_tare(), pick_gain());
				if (k == 0)
					hold_request = 1'b1;
				repeat (GROUPS_PER_SETTING) send_random_group();
			end
		end

		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES * 3) @(posedge clk);
		$display("sent %0d samples under %0d register settings and three pacing modes",
			samples_sent, settings_used);
		$display("checked %0d readings, %0d of them clipped", checked, clipped);
		if (fail_count == 0)
			$display("load_cell_trimmed_mean_scaler_unit_tb: PASS");
		else
			$display("load_cell_trimmed_mean_scaler_unit_tb: FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/lcts_pkg.sv
src/load_cell_trimmed_mean_scaler_unit.sv
bench/load_cell_reading_checker.sv
bench/load_cell_trimmed_mean_scaler_unit_tb.sv
